[design/esp_pkg.sv]
// Shared types and codes of the entity slot pool.
// Used by the front, back, top level and checker; depends on nothing.
`default_nettype none
package esp_pkg;

   localparam int FIELD_W = 16;
   localparam int SLOT_W  = 5;
   localparam int MODE_W  = 2;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 6;
   localparam int RECT_W  = 4 * FIELD_W;

   localparam logic [MODE_W-1:0] OP_ADD  = 2'd0;
   localparam logic [MODE_W-1:0] OP_FREE = 2'd1;
   localparam logic [MODE_W-1:0] OP_WALK = 2'd2;
   localparam logic [MODE_W-1:0] OP_NONE = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WALK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

   localparam logic               CSR_SLOT_LIMIT   = 1'b0;
   localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 6'd32;

   typedef struct packed {
      logic [MODE_W-1:0]  op;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] w;
      logic [FIELD_W-1:0] h;
      logic [SLOT_W-1:0]  index;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               ok;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] w;
      logic [FIELD_W-1:0] h;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

[design/esp_front.sv]
// Front of the entity slot pool: accepts requests, drops the unused mode and
// queues commands in a two-entry queue. Depends on esp_pkg.
`default_nettype none
module esp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire esp_pkg::cmd_type      in_cmd,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output esp_pkg::cmd_type           cmd
);
   import esp_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign push      = in_valid && in_ready && (in_cmd.op != OP_NONE);
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule
`default_nettype wire

[design/esp_back.sv]
// Back of the entity slot pool: slot bookkeeping, rectangle memory, walk
// sequencer and the result register. Depends on esp_pkg.
`default_nettype none
module esp_back #(
   parameter int POOL_SLOTS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [esp_pkg::LIMIT_W-1:0] slot_limit,
   input  wire logic                        cmd_valid,
   output logic                             cmd_ready,
   input  wire esp_pkg::cmd_type            cmd,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output esp_pkg::rsp_type                 out
);
   import esp_pkg::*;

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam int CNT_W = $clog2(POOL_SLOTS + 1);
   localparam logic [POOL_SLOTS-1:0] ONE_V = POOL_SLOTS'(1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   function automatic logic [IDX_W-1:0] lowest(input logic [POOL_SLOTS-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   logic [1:0]            state_ff, state_in;
   logic [POOL_SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]      hw_ff, hw_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [IDX_W-1:0]      slot_q_ff, slot_q_in;
   logic                  last_q_ff, last_q_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic [RECT_W-1:0]     rect_mem [POOL_SLOTS];
   logic [RECT_W-1:0]     rdata_ff;

   logic                  mem_we, mem_re;
   logic [IDX_W-1:0]      mem_waddr;
   logic [POOL_SLOTS-1:0] below_hw, at_ptr, free_vec, avail;
   logic [IDX_W-1:0]      free_idx, next_idx;
   logic                  free_found, can_append, free_ok, next_last, out_free;
   logic [LIMIT_W:0]      limit;

   always_comb begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         below_hw[i] = (CNT_W'(i) < hw_ff);
         at_ptr[i]   = (IDX_W'(i) >= ptr_ff);
      end
   end

   assign free_vec   = ~used_ff & below_hw;
   assign free_found = |free_vec;
   assign free_idx   = lowest(free_vec);
   assign limit      = (int'(slot_limit) < POOL_SLOTS) ? (LIMIT_W + 1)'(slot_limit)
                                                       : (LIMIT_W + 1)'(POOL_SLOTS);
   assign can_append = ((LIMIT_W + 1)'(hw_ff) < limit);
   assign free_ok    = (int'(cmd.index) < POOL_SLOTS)
                       && ((LIMIT_W + 1)'(cmd.index) < (LIMIT_W + 1)'(hw_ff));
   assign avail      = used_ff & at_ptr;
   assign next_idx   = lowest(avail);
   assign next_last  = ((avail & (avail - ONE_V)) == '0);
   assign out_free   = !out_valid_ff || out_ready;
   assign cmd_ready  = (state_ff == ST_IDLE) && out_free;
   assign out_valid  = out_valid_ff;
   assign out        = out_ff;

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      hw_in        = hw_ff;
      ptr_in       = ptr_ff;
      slot_q_in    = slot_q_ff;
      last_q_in    = last_q_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = free_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               out_in      = '0;
               out_in.last = 1'b1;
               unique case (cmd.op)
                  OP_ADD: begin
                     out_valid_in = 1'b1;
                     out_in.kind  = KIND_ADD;
                     if (free_found) begin
                        mem_we            = 1'b1;
                        used_in[free_idx] = 1'b1;
                        out_in.ok         = 1'b1;
                        out_in.slot       = SLOT_W'(free_idx);
                     end else if (can_append) begin
                        mem_we             = 1'b1;
                        mem_waddr          = hw_ff[IDX_W-1:0];
                        used_in[mem_waddr] = 1'b1;
                        hw_in              = hw_ff + CNT_W'(1);
                        out_in.ok          = 1'b1;
                        out_in.slot        = SLOT_W'(hw_ff[IDX_W-1:0]);
                     end
                  end
                  OP_FREE: begin
                     out_valid_in = 1'b1;
                     out_in.kind  = KIND_FREE;
                     out_in.ok    = free_ok;
                     out_in.slot  = cmd.index;
                     if (free_ok) used_in[cmd.index[IDX_W-1:0]] = 1'b0;
                  end
                  OP_WALK: begin
                     if (used_ff == '0) begin
                        out_valid_in = 1'b1;
                        out_in.kind  = KIND_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            mem_re    = 1'b1;
            slot_q_in = next_idx;
            last_q_in = next_last;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.kind  = KIND_WALK;
               out_in.ok    = 1'b0;
               out_in.slot  = SLOT_W'(slot_q_ff);
               out_in.x     = rdata_ff[FIELD_W-1:0];
               out_in.y     = rdata_ff[2*FIELD_W-1:FIELD_W];
               out_in.w     = rdata_ff[3*FIELD_W-1:2*FIELD_W];
               out_in.h     = rdata_ff[4*FIELD_W-1:3*FIELD_W];
               out_in.last  = last_q_ff;
               if (last_q_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = slot_q_ff + IDX_W'(1);
                  state_in = ST_WALK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         hw_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         hw_ff        <= hw_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      slot_q_ff <= slot_q_in;
      last_q_ff <= last_q_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) rect_mem[mem_waddr] <= {cmd.h, cmd.w, cmd.y, cmd.x};
      if (mem_re) rdata_ff <= rect_mem[next_idx];
   end

endmodule
`default_nettype wire

[design/entity_slot_pool.sv]
// Top level of the entity slot pool: register port, front queue and back.
// Depends on esp_pkg, esp_front and esp_back.
//
//   Channel   Ports     Direction  Carries
//   request   req_*     in         add, free or walk command
//   response  rsp_*     out        add/free answer, walk entries
//   csr       csr_*     in/out     slot_limit at byte address 0
//
// An add or free passes through the queue register and then the result
// register of the back. A walk gives one result per used slot: ST_WALK reads
// the rectangle memory into a register and ST_WAIT sends it out. Requests are
// accepted while the two-entry queue has room, also while a result stalls.
// Reset clears the used marks and the high-water mark at once.
`default_nettype none
module entity_slot_pool #(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pos_x[15:0], pos_y[31:16], rect_width[47:32], rect_height[63:48],
   // slot_index[68:64], zero[71:69]
   input  wire logic [71:0] req_tdata,
   // mode[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // ok[0], slot[5:1], out_x[21:6], out_y[37:22], out_width[53:38],
   // out_height[69:54], zero[71:70]
   output logic [71:0]      rsp_tdata,
   // kind[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import esp_pkg::*;

   localparam int POOL_SLOTS = (SLOT_COUNT < 32) ? SLOT_COUNT : 32;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_we;
   cmd_type            in_cmd, cmd;
   logic               cmd_valid, cmd_ready;
   rsp_type            out;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_SLOT_LIMIT);
   assign limit_in   = csr_we ? csr_pwdata[LIMIT_W-1:0] : limit_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_SLOT_LIMIT) ? 32'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SLOT_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      in_cmd.op    = req_tuser;
      in_cmd.x     = req_tdata[15:0];
      in_cmd.y     = req_tdata[31:16];
      in_cmd.w     = req_tdata[47:32];
      in_cmd.h     = req_tdata[63:48];
      in_cmd.index = req_tdata[68:64];
   end

   esp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   esp_back #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .slot_limit (limit_ff),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out        (out)
   );

   assign rsp_tdata = {2'b00, out.h, out.w, out.y, out.x, out.slot, out.ok};
   assign rsp_tuser = out.kind;
   assign rsp_tlast = out.last;

endmodule
`default_nettype wire

[design/esp_checker.sv]
// Port-level checks of the entity slot pool and the bind that attaches them.
// Depends on esp_pkg and entity_slot_pool.
`default_nettype none
module esp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import esp_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_WALK) |-> rsp_tlast)
      else $error("single answer without last");

   a_walk_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_WALK) |-> !rsp_tdata[0])
      else $error("walk entry with ok set");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EMPTY) |-> (rsp_tdata == '0))
      else $error("empty walk with nonzero data");

endmodule

bind entity_slot_pool esp_checker u_esp_checker (.*);
`default_nettype wire
